/* rtl/frq_pkg.sv */
// Shared types and constants for the ready queue with keyed removal.
// Holds the command and status codes and the fixed field widths.
// Depends on nothing; the queue unit imports it.
package frq_pkg;

   // Fixed field widths of the request and response beats.
   localparam int CMD_W    = 2;
   localparam int REQ_ID_W = 16;
   localparam int TICK_W   = 32;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 9;

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [REQ_ID_W-1:0] req_id_type;
   typedef logic [TICK_W-1:0]   tick_type;
   typedef logic [OCC_W-1:0]    occ_type;

   // Command codes.
   localparam cmd_type CMD_ENQUEUE = 2'd0;
   localparam cmd_type CMD_DEQUEUE = 2'd1;
   localparam cmd_type CMD_REMOVE  = 2'd2;
   localparam cmd_type CMD_REQUEUE = 2'd3;

   // Status codes.
   localparam status_type STATUS_OK         = 2'd0;
   localparam status_type STATUS_FULL_EMPTY = 2'd1;
   localparam status_type STATUS_NOT_FOUND  = 2'd2;

endpackage

/* rtl/fifo_ready_queue_with_removal_unit.sv */
// Ready queue of process ids with arrival times, with keyed removal and requeue.
// Uses frq_pkg for codes and widths and frq_ram for the entry store.
//
//   Channel   Handshake          Fields
//   request   start, busy        req_command, req_process_id, req_now_ticks
//   response  rsp_valid strobe   rsp_status, rsp_result_id, rsp_arrival_ticks,
//                                rsp_occupancy
//
// One request is worked at a time. The response strobe rises in the same cycle
// that busy falls. A full enqueue or an empty dequeue never raises busy. A
// dequeue passes through a single read state. The store is one RAM walked one
// entry per cycle, with N entries queued. A search walks from the head to a
// match or the tail; a miss appends unless a removal or the queue is full.
// A hit on removal shifts on from the match; requeue adds the append. Reset
// clears the state, pointers, count and flags only. The receiver cannot stall.
module fifo_ready_queue_with_removal_unit #(
   parameter int QUEUE_DEPTH = 256,
   parameter int ID_BITS     = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  frq_pkg::cmd_type        req_command,
   input  frq_pkg::req_id_type     req_process_id,
   input  frq_pkg::tick_type       req_now_ticks,
   output logic                    rsp_valid,
   output frq_pkg::status_type     rsp_status,
   output frq_pkg::req_id_type     rsp_result_id,
   output frq_pkg::tick_type       rsp_arrival_ticks,
   output frq_pkg::occ_type        rsp_occupancy
);

   import frq_pkg::*;

   // Derived sizes.
   localparam int IdW   = (ID_BITS < REQ_ID_W) ? ID_BITS : REQ_ID_W;
   localparam int AW    = $clog2(QUEUE_DEPTH);
   localparam int CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int EntW  = IdW + TICK_W;

   localparam logic [CW-1:0] COUNT_FULL = CW'(QUEUE_DEPTH);
   localparam logic [AW-1:0] LAST_SLOT  = AW'(QUEUE_DEPTH - 1);
   localparam logic [AW:0]   DEPTH_WIDE = (AW + 1)'(QUEUE_DEPTH);

   // Sequencer state codes.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SEARCH = 3'd1;
   localparam logic [2:0] ST_SHIFT  = 3'd2;
   localparam logic [2:0] ST_APPEND = 3'd3;
   localparam logic [2:0] ST_DEQ    = 3'd4;

   // Physical slot of an offset from the head.
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                             input logic [CW-1:0] off);
      logic [AW:0] sum;
      sum = (AW + 1)'(head) + (AW + 1)'(off);
      if (sum >= DEPTH_WIDE) begin
         sum = sum - DEPTH_WIDE;
      end
      return sum[AW-1:0];
   endfunction

   logic [2:0]       state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [IdW-1:0]   id_ff, id_in;
   tick_type         now_ff, now_in;
   logic [AW-1:0]    head_ff, head_in;
   logic [AW-1:0]    tail_ff, tail_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    scan_off_ff, scan_off_in;
   logic             pend_ff, pend_in;
   logic [CW-1:0]    pend_off_ff, pend_off_in;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   req_id_type       rsp_id_ff, rsp_id_in;
   tick_type         rsp_arr_ff, rsp_arr_in;
   occ_type          rsp_occ_ff, rsp_occ_in;

   logic             ram_wr_en;
   logic [AW-1:0]    ram_wr_addr;
   logic [EntW-1:0]  ram_wr_data;
   logic             ram_rd_en;
   logic [AW-1:0]    ram_rd_addr;
   logic [EntW-1:0]  ram_rd_data;
   logic [IdW-1:0]   rd_id;
   tick_type         rd_time;

   logic             accept;
   logic             hit;
   logic             more;
   logic [IdW-1:0]   req_id;

   // Entry store: id in the upper bits, arrival time in the lower bits.
   frq_ram #(
      .WIDTH (EntW),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_id   = ram_rd_data[EntW-1:TICK_W];
   assign rd_time = ram_rd_data[TICK_W-1:0];
   assign req_id  = req_process_id[IdW-1:0];
   assign accept  = start && (state_ff == ST_IDLE);
   assign hit     = pend_ff && (rd_id == id_ff);
   assign more    = scan_off_ff < count_ff;

   // Sequencer: search, shift, append and dequeue over the entry store.
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      id_in        = id_ff;
      now_in       = now_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      scan_off_in  = scan_off_ff;
      pend_in      = 1'b0;
      pend_off_in  = pend_off_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_arr_in    = rsp_arr_ff;
      rsp_occ_in    = rsp_occ_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = tail_ff;
      ram_wr_data  = {id_ff, now_ff};
      ram_rd_en    = 1'b0;
      ram_rd_addr  = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in      = req_command;
               id_in       = req_id;
               now_in      = req_now_ticks;
               scan_off_in = '0;
               rsp_id_in   = REQ_ID_W'(req_id);
               rsp_arr_in  = '0;
               rsp_occ_in  = OCC_W'(count_ff);
               if (req_command == CMD_ENQUEUE && count_ff == COUNT_FULL) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_FULL_EMPTY;
               end else if (req_command == CMD_DEQUEUE) begin
                  if (count_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_FULL_EMPTY;
                  end else begin
                     ram_rd_en = 1'b1;
                     state_in  = ST_DEQ;
                  end
               end else begin
                  state_in = ST_SEARCH;
               end
            end
         end

         ST_SEARCH: begin
            if (hit) begin
               if (cmd_ff == CMD_ENQUEUE) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_OK;
                  rsp_arr_in    = rd_time;
                  rsp_occ_in    = OCC_W'(count_ff);
                  state_in      = ST_IDLE;
               end else begin
                  scan_off_in = pend_off_ff + CW'(1);
                  state_in    = ST_SHIFT;
               end
            end else if (!more) begin
               // Walked the whole window without a match.
               if (cmd_ff == CMD_REMOVE) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_NOT_FOUND;
                  rsp_arr_in    = '0;
                  rsp_occ_in    = OCC_W'(count_ff);
                  state_in      = ST_IDLE;
               end else if (count_ff != COUNT_FULL) begin
                  state_in = ST_APPEND;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_OK;
                  rsp_arr_in    = '0;
                  rsp_occ_in    = OCC_W'(count_ff);
                  state_in      = ST_IDLE;
               end
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = slot_of(head_ff, scan_off_ff);
               pend_in     = 1'b1;
               pend_off_in = scan_off_ff;
               scan_off_in = scan_off_ff + CW'(1);
            end
         end

         ST_SHIFT: begin
            // Write back the entry read last cycle one place toward the head.
            ram_wr_en   = pend_ff;
            ram_wr_addr = slot_of(head_ff, pend_off_ff);
            ram_wr_data = ram_rd_data;
            if (more) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = slot_of(head_ff, scan_off_ff);
               pend_in     = 1'b1;
               pend_off_in = scan_off_ff - CW'(1);
               scan_off_in = scan_off_ff + CW'(1);
            end else begin
               count_in = count_ff - CW'(1);
               tail_in  = (tail_ff == '0) ? LAST_SLOT : tail_ff - AW'(1);
               if (cmd_ff == CMD_REQUEUE) begin
                  state_in = ST_APPEND;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_OK;
                  rsp_arr_in    = '0;
                  rsp_occ_in    = OCC_W'(count_ff - CW'(1));
                  state_in      = ST_IDLE;
               end
            end
         end

         ST_APPEND: begin
            ram_wr_en     = 1'b1;
            ram_wr_addr   = tail_ff;
            ram_wr_data   = {id_ff, now_ff};
            tail_in       = (tail_ff == LAST_SLOT) ? '0 : tail_ff + AW'(1);
            count_in      = count_ff + CW'(1);
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_arr_in    = now_ff;
            rsp_occ_in    = OCC_W'(count_ff + CW'(1));
            state_in      = ST_IDLE;
         end

         ST_DEQ: begin
            head_in       = (head_ff == LAST_SLOT) ? '0 : head_ff + AW'(1);
            count_in      = count_ff - CW'(1);
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_id_in     = REQ_ID_W'(rd_id);
            rsp_arr_in    = rd_time;
            rsp_occ_in    = OCC_W'(count_ff - CW'(1));
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      id_ff         <= id_in;
      now_ff        <= now_in;
      scan_off_ff   <= scan_off_in;
      pend_off_ff   <= pend_off_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_arr_ff    <= rsp_arr_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_result_id     = rsp_id_ff;
   assign rsp_arrival_ticks = rsp_arr_ff;
   assign rsp_occupancy     = rsp_occ_ff;

endmodule

/* rtl/frq_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// Width and depth are parameters; no reset and no dependencies.
module frq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
